/* rtl/wmac_pkg.sv */
// Package for the word multiply-accumulate checksum block.
// Holds the seed constants, queue sizing and the operation type passed
// from the front end to the back end. No dependencies.
package wmac_pkg;

  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int BYTE_W      = 8;
  localparam int PART_W      = 56;
  localparam int HELD_W      = 3;
  localparam logic [HELD_W-1:0] HELD_LAST = 3'd7;

  localparam logic [WORD_W-1:0] SEED_WEIGHT = 64'h794e80091e8f2bc7;
  localparam logic [WORD_W-1:0] SEED_ACCUM  = 64'hc20f9a8b761b7e4c;

  // Queue depth must be a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              restart;
    logic              has_word;
    logic              emit;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mul_weight;
    logic [WORD_W-1:0] emit_weight;
  } op_t;

endpackage

/* rtl/wmac_if.sv */
// Handshake channel interfaces for the checksum block.
// wmac_in_if carries input bytes, wmac_out_if carries checksums.
// Both take their field widths from wmac_pkg.
interface wmac_in_if;
  import wmac_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              restart;
  logic              chunk_end;

  modport source (output valid, output data_byte, output restart, output chunk_end,
                  input ready);
  modport sink   (input valid, input data_byte, input restart, input chunk_end,
                  output ready);
endinterface

interface wmac_out_if;
  import wmac_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] checksum_value;

  modport source (output valid, output checksum_value, input ready);
  modport sink   (input valid, input checksum_value, output ready);
endinterface

/* rtl/wmac_front.sv */
// Front end: accepts bytes, packs them little-endian into 64-bit words and
// tracks the weight, issuing one operation per event into the queue.
// Depends on wmac_pkg and wmac_in_if.
module wmac_front
  import wmac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wmac_in_if.sink    in_bus,
  output op_t        push_op,
  output logic       push_valid,
  input  logic       push_ready
);

  logic [PART_W-1:0] partial_r, partial_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [WORD_W-1:0] weight_r, weight_nxt;

  logic [PART_W-1:0] part_base;
  logic [HELD_W-1:0] held_base;
  logic [WORD_W-1:0] weight_base;
  logic              word_done;
  logic              accept;

  assign in_bus.ready = push_ready;
  assign accept       = in_bus.valid && push_ready;

  always_comb begin
    part_base   = in_bus.restart ? '0 : partial_r;
    held_base   = in_bus.restart ? '0 : held_r;
    weight_base = in_bus.restart ? SEED_WEIGHT : weight_r;
    word_done   = (held_base == HELD_LAST);

    partial_nxt = part_base;
    held_nxt    = held_base + 1'b1;
    weight_nxt  = weight_base;
    if (word_done) begin
      partial_nxt = '0;
      held_nxt    = '0;
      weight_nxt  = weight_base + 1'b1;
    end else begin
      partial_nxt[{held_base, 3'b000} +: BYTE_W] = in_bus.data_byte;
    end

    push_op.restart     = in_bus.restart;
    push_op.has_word    = word_done;
    push_op.emit        = in_bus.chunk_end;
    push_op.word        = {in_bus.data_byte, part_base};
    push_op.mul_weight  = weight_base;
    push_op.emit_weight = weight_nxt;
  end

  // Bytes that neither finish a word, restart nor end a chunk leave the
  // back end untouched, so no transfer into the queue is made for them.
  assign push_valid = in_bus.valid &&
                      (in_bus.restart || word_done || in_bus.chunk_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      held_r    <= '0;
      weight_r  <= SEED_WEIGHT;
    end else if (accept) begin
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
      weight_r  <= weight_nxt;
    end
  end

endmodule

/* rtl/wmac_queue.sv */
// Short queue of operations between the front and back ends.
// Flip-flop storage with a single registered read pointer.
// Depends on wmac_pkg.
module wmac_queue
  import wmac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  op_t  push_op,
  input  logic push_valid,
  output logic push_ready,
  output op_t  pop_op,
  output logic pop_valid,
  input  logic pop_ready
);

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/wmac_back.sv */
// Back end: pipelined 64-bit wrapping multiply from 32-bit partial products,
// accumulator update and the registered checksum output.
// Depends on wmac_pkg and wmac_out_if.
module wmac_back
  import wmac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        pop_op,
  input  logic       pop_valid,
  output logic       pop_ready,
  wmac_out_if.source out_bus
);

  // Partial product stage.
  logic              m_v_r;
  logic              m_restart_r, m_word_r, m_emit_r;
  logic [WORD_W-1:0] m_p0_r;
  logic [HALF_W-1:0] m_p1_r, m_p2_r;
  logic [WORD_W-1:0] m_ew_r;

  // Product sum stage.
  logic              s_v_r;
  logic              s_restart_r, s_word_r, s_emit_r;
  logic [WORD_W-1:0] s_prod_r;
  logic [WORD_W-1:0] s_ew_r;

  // Accumulate stage.
  logic              c_v_r;
  logic              c_emit_r;
  logic [WORD_W-1:0] c_acc_r;
  logic [WORD_W-1:0] c_ew_r;
  logic [WORD_W-1:0] acc_r;

  logic              out_v_r;
  logic [WORD_W-1:0] out_val_r;

  logic              out_free, c_adv, c_free, s_free, m_free;
  logic [WORD_W-1:0] acc_new;
  logic [HALF_W-1:0] cross_sum;

  assign out_free  = !out_v_r || out_bus.ready;
  assign c_adv     = c_v_r && (!c_emit_r || out_free);
  assign c_free    = !c_v_r || c_adv;
  assign s_free    = !s_v_r || c_free;
  assign m_free    = !m_v_r || s_free;
  assign pop_ready = m_free;

  assign out_bus.valid          = out_v_r;
  assign out_bus.checksum_value = out_val_r;

  // Only the low halves of the cross products reach bits below 2^64.
  assign cross_sum = m_p1_r + m_p2_r;

  always_comb begin
    acc_new = s_restart_r ? SEED_ACCUM : acc_r;
    if (s_word_r) begin
      acc_new = acc_new + s_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && pop_valid) begin
      m_restart_r <= pop_op.restart;
      m_word_r    <= pop_op.has_word;
      m_emit_r    <= pop_op.emit;
      m_p0_r      <= WORD_W'(pop_op.word[HALF_W-1:0]) *
                     WORD_W'(pop_op.mul_weight[HALF_W-1:0]);
      m_p1_r      <= HALF_W'(pop_op.word[HALF_W-1:0] * pop_op.mul_weight[WORD_W-1:HALF_W]);
      m_p2_r      <= HALF_W'(pop_op.word[WORD_W-1:HALF_W] * pop_op.mul_weight[HALF_W-1:0]);
      m_ew_r      <= pop_op.emit_weight;
    end
    if (s_free && m_v_r) begin
      s_restart_r <= m_restart_r;
      s_word_r    <= m_word_r;
      s_emit_r    <= m_emit_r;
      s_prod_r    <= m_p0_r + {cross_sum, {HALF_W{1'b0}}};
      s_ew_r      <= m_ew_r;
    end
    if (c_free && s_v_r) begin
      c_emit_r <= s_emit_r;
      c_acc_r  <= acc_new;
      c_ew_r   <= s_ew_r;
    end
    if (out_free && c_v_r && c_emit_r) begin
      out_val_r <= c_acc_r + c_ew_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= SEED_ACCUM;
    end else begin
      if (m_free) begin
        m_v_r <= pop_valid;
      end
      if (s_free) begin
        s_v_r <= m_v_r;
      end
      if (c_free) begin
        c_v_r <= s_v_r;
        if (s_v_r) begin
          acc_r <= acc_new;
        end
      end
      if (out_free) begin
        out_v_r <= c_v_r && c_emit_r;
      end
    end
  end

endmodule

/* rtl/word_multiply_accumulate_checksum.sv */
// Word multiply-accumulate checksum, top level.
// Throughput: one byte per cycle while the queue has room; output back-pressure can stall it.
// Path: after its byte's transfer a checksum passes the queue, the partial products, product sum
// and accumulate stages and the output register; a stalled output holds it.
// Reset: synchronous, active low; seeds are loaded at once, no clearing pass.
// Depends on wmac_pkg, wmac_if, wmac_front, wmac_queue and wmac_back.
module word_multiply_accumulate_checksum
  import wmac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wmac_in_if.sink    in_bus,
  wmac_out_if.source out_bus
);

  op_t  push_op, pop_op;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;

  wmac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  wmac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  wmac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_op    (pop_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_bus   (out_bus)
  );

endmodule
